// File: rtl/brf_pkg.sv
// Shared types and constants of the byte ring FIFO.
package brf_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_AW   = 2;
  localparam int unsigned LVL_W     = 3;

  localparam logic [CFG_W-1:0] SIZE_LOG2_MIN = 4'd1;
  localparam logic [CFG_W-1:0] SIZE_LOG2_MAX = 4'd8;
  localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 4'd8;

  localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_BULK  = 3'd2;
  localparam logic [OP_W-1:0] OP_STR   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERRUN  = 2'd1,
    ST_UNDERRUN = 2'd2,
    ST_NOSTR    = 2'd3
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  free_count;
    logic              last;
  } res_t;

  // One result slot on its way to the output buffer.
  typedef struct packed {
    logic valid;
    logic use_mem;
    res_t res;
  } slot_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// File: rtl/brf_ram.sv
// Ring storage: one write port, one read port, registered read data.
module brf_ram import brf_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/brf_obuf.sv
// Small result buffer in front of the output channel.
module brf_obuf import brf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output res_t             head_o,
  output logic [LVL_W-1:0] level_o
);

  res_t               buf_q [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wp_q, rp_q;
  logic [LVL_W-1:0]   cnt_q;
  logic               do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = buf_q[rp_q];
  assign level_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wp_q <= wp_q + OBUF_AW'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + OBUF_AW'(1);
      end
      cnt_q <= cnt_q + LVL_W'(push_i.valid) - LVL_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      buf_q[wp_q] <= push_i.res;
    end
  end

endmodule

// File: rtl/brf_ctrl.sv
// Operation sequencer: index bookkeeping, memory walks and result slots.
module brf_ctrl import brf_pkg::*; #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CFG_W-1:0]         size_log2_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [DATA_W-1:0]        din_i,
  input  logic [LEN_W-1:0]         len_i,
  input  logic [LVL_W-1:0]         obuf_level_i,
  output push_t                    push_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [DATA_W-1:0]        ram_wdata_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [DATA_W-1:0]        ram_rdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_READ);

  typedef enum logic [1:0] {S_IDLE, S_BULK, S_SCAN, S_SOLO} state_e;

  state_e           state_q, state_d;
  logic [IW-1:0]    rd_q, rd_d, wr_q, wr_d;
  logic [IW-1:0]    cur_q, cur_d, start_q, start_d;
  logic [CNT_W-1:0] left_q, left_d, pos_q, pos_d;
  logic [CNT_W-1:0] n_q, n_d, free_q, free_d;
  logic [CNT_W-1:0] chk_pos_q, chk_pos_d;
  logic             chk_v_q, chk_v_d, chk_last_q, chk_last_d;
  logic             term_q, term_d;
  status_e          stat_q, stat_d;
  slot_t            s1_q, slot;

  logic [CFG_W-1:0] sl;
  logic [8:0]       m9;
  logic [IW-1:0]    m, r, w, fill, nw;
  logic [CNT_W-1:0] fill8, fr8, len8, n_len, lim;
  logic             room, accept, found, issue;

  // Clamp the size register and build the index mask.
  always_comb begin
    if (size_log2_i < SIZE_LOG2_MIN) begin
      sl = SIZE_LOG2_MIN;
    end else if (size_log2_i > SIZE_LOG2_MAX) begin
      sl = SIZE_LOG2_MAX;
    end else begin
      sl = size_log2_i;
    end
  end

  assign m9    = (9'd1 << sl) - 9'd1;
  assign m     = IW'(m9);
  assign r     = rd_q & m;
  assign w     = wr_q & m;
  assign nw    = (w + IW'(1)) & m;
  assign fill  = (w - r) & m;
  assign fill8 = CNT_W'(fill);
  assign fr8   = CNT_W'(m - fill);
  assign len8  = (CNT_W'(len_i) > MAX_LEN) ? MAX_LEN : CNT_W'(len_i);
  assign n_len = (fill8 < len8) ? fill8 : len8;
  assign lim   = n_len;

  assign room = ({1'b0, obuf_level_i} + (LVL_W+1)'(s1_q.valid)) < (LVL_W+1)'(OBUF_DEPTH);
  assign in_ready_o = (state_q == S_IDLE) && room;
  assign accept     = in_valid_i && in_ready_o;

  assign found = chk_v_q && (ram_rdata_i == '0);
  assign issue = (state_q == S_SCAN) && (left_q != '0) && !found;

  assign ram_raddr_o = (state_q == S_IDLE) ? r : cur_q;
  assign ram_waddr_o = w;
  assign ram_wdata_o = din_i;

  always_comb begin
    state_d    = state_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    cur_d      = cur_q;
    start_d    = start_q;
    left_d     = left_q;
    pos_d      = pos_q;
    n_d        = n_q;
    free_d     = free_q;
    term_d     = term_q;
    stat_d     = stat_q;
    chk_pos_d  = chk_pos_q;
    chk_last_d = chk_last_q;
    chk_v_d    = 1'b0;
    ram_we_o   = 1'b0;
    slot       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_d = r;
          wr_d = w;
          unique case (op_i)
            OP_ENQ: begin
              slot.valid          = 1'b1;
              slot.res.last       = 1'b1;
              if (nw != r) begin
                ram_we_o            = 1'b1;
                wr_d                = nw;
                slot.res.status     = ST_OK;
                slot.res.count      = CNT_W'(1);
                slot.res.free_count = fr8 - CNT_W'(1);
              end else begin
                slot.res.status     = ST_OVERRUN;
                slot.res.free_count = fr8;
              end
            end
            OP_DEQ: begin
              slot.valid    = 1'b1;
              slot.res.last = 1'b1;
              if (r != w) begin
                rd_d                = (r + IW'(1)) & m;
                slot.use_mem        = 1'b1;
                slot.res.status     = ST_OK;
                slot.res.count      = CNT_W'(1);
                slot.res.free_count = fr8 + CNT_W'(1);
              end else begin
                slot.res.status     = ST_UNDERRUN;
                slot.res.free_count = fr8;
              end
            end
            OP_BULK: begin
              if (n_len == '0) begin
                // Nothing to take: lone terminator.
                slot.valid          = 1'b1;
                slot.res.status     = ST_OK;
                slot.res.free_count = fr8;
                slot.res.last       = 1'b1;
              end else begin
                cur_d   = r;
                left_d  = n_len;
                n_d     = n_len;
                free_d  = fr8 + n_len;
                term_d  = (n_len < len8);
                stat_d  = ST_OK;
                rd_d    = (r + IW'(n_len)) & m;
                state_d = S_BULK;
              end
            end
            OP_STR: begin
              if (lim == '0) begin
                slot.valid          = 1'b1;
                slot.res.status     = ST_NOSTR;
                slot.res.free_count = fr8;
                slot.res.last       = 1'b1;
              end else begin
                cur_d   = r;
                start_d = r;
                left_d  = lim;
                pos_d   = '0;
                free_d  = fr8;
                state_d = S_SCAN;
              end
            end
            default: begin
              slot.valid          = 1'b1;
              slot.res.status     = ST_OK;
              slot.res.count      = fill8;
              slot.res.free_count = fr8;
              slot.res.last       = 1'b1;
            end
          endcase
        end
      end

      S_BULK: begin
        if (room) begin
          slot.valid          = 1'b1;
          slot.use_mem        = 1'b1;
          slot.res.status     = ST_OK;
          slot.res.count      = n_q;
          slot.res.free_count = free_q;
          slot.res.last       = (left_q == CNT_W'(1)) && !term_q;
          cur_d               = (cur_q + IW'(1)) & m;
          left_d              = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = term_q ? S_SOLO : S_IDLE;
          end
        end
      end

      S_SCAN: begin
        // Issue one read a cycle, check the byte returned from the previous one.
        if (issue) begin
          cur_d      = (cur_q + IW'(1)) & m;
          left_d     = left_q - CNT_W'(1);
          pos_d      = pos_q + CNT_W'(1);
          chk_pos_d  = pos_q;
          chk_last_d = (left_q == CNT_W'(1));
          chk_v_d    = 1'b1;
        end
        if (found) begin
          rd_d   = (start_q + IW'(chk_pos_q) + IW'(1)) & m;
          n_d    = chk_pos_q;
          free_d = free_q + chk_pos_q + CNT_W'(1);
          stat_d = ST_OK;
          term_d = 1'b1;
          cur_d  = start_q;
          left_d = chk_pos_q;
          if (chk_pos_q == '0) begin
            state_d = S_SOLO;
          end else begin
            state_d = S_BULK;
          end
        end else if (chk_v_q && chk_last_q) begin
          n_d     = '0;
          stat_d  = ST_NOSTR;
          state_d = S_SOLO;
        end
      end

      S_SOLO: begin
        if (room) begin
          slot.valid          = 1'b1;
          slot.res.status     = stat_q;
          slot.res.count      = n_q;
          slot.res.free_count = free_q;
          slot.res.last       = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Merge the memory byte into the slot registered in the previous cycle.
  always_comb begin
    push_o.valid = s1_q.valid;
    push_o.res   = s1_q.res;
    if (s1_q.use_mem) begin
      push_o.res.data = ram_rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_q       <= '0;
      wr_q       <= '0;
      cur_q      <= '0;
      start_q    <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      n_q        <= '0;
      free_q     <= '0;
      term_q     <= 1'b0;
      stat_q     <= ST_OK;
      chk_pos_q  <= '0;
      chk_last_q <= 1'b0;
      chk_v_q    <= 1'b0;
      s1_q       <= '0;
    end else begin
      state_q    <= state_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      cur_q      <= cur_d;
      start_q    <= start_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      n_q        <= n_d;
      free_q     <= free_d;
      term_q     <= term_d;
      stat_q     <= stat_d;
      chk_pos_q  <= chk_pos_d;
      chk_last_q <= chk_last_d;
      chk_v_q    <= chk_v_d;
      s1_q       <= slot;
    end
  end

endmodule

// File: rtl/byte_ring_fifo.sv
// Top level of the byte ring FIFO: channels, size register and submodules.
//
// Byte FIFO on a power-of-two ring with one slot always kept empty.
// Input channel (s_axis_*): one command item per handshake; tuser carries
// the opcode, tdata the byte to enqueue and the read length.
// Output channel (m_axis_*): result items; tdata carries the byte, the
// count and the free count, tuser the status, tlast marks the final item
// of a command. Every command yields at least one item.
// Config channel (cfg_*): writes log2 of the ring size in use; write it only
// while the block is idle. It is always ready.
// A one-item result passes the sequencer's result slot register and the
// result buffer before it leaves. Throughput: enqueue, dequeue and query
// complete in the idle state; a bulk read emits one byte a cycle while the
// result buffer has room, plus a terminator if it runs short; a string read
// scans one byte a cycle, then emits one byte a cycle while the buffer has
// room, plus the terminator. The ring's single read port sets these rates.
// Reset: both indices go to zero, the size register to its largest value;
// the ring contents are not cleared.
// Stall: a four-entry result buffer absorbs results; when it fills, the
// block stops issuing and holds s_axis_tready low until space frees.
module byte_ring_fifo import brf_pkg::*; #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_in, [13:8] max_length, [15:14] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_out, [15:8] count, [23:16] free_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,   // last
  // Size register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic [CFG_W-1:0]  size_log2_q;
  logic [LVL_W-1:0]  level;
  push_t             push;
  res_t              head;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  // Hold the size register; it is only sampled by the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_LOG2_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_log2_q <= cfg_data_i;
    end
  end

  brf_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_log2_i  (size_log2_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .din_i        (s_axis_tdata[7:0]),
    .len_i        (s_axis_tdata[13:8]),
    .obuf_level_i (level),
    .push_o       (push),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  brf_ram #(
    .AW (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brf_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .level_o (level)
  );

  // Drive the result channel straight from the buffer head.
  assign m_axis_tdata = {head.free_count, head.count, head.data};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.last;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the byte ring FIFO: directed and random commands, scoreboard.
`timescale 1ns / 100ps

module tb import brf_pkg::*; ();

  localparam int MAX_LEN     = 32;
  localparam int RING_SLOTS  = 256;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] data_in, [13:8] max_length, [15:14] zero
  logic [2:0]  s_axis_tuser;   // [2:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] data_out, [15:8] count, [23:16] free_count
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;

  byte_ring_fifo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the ring: contents, write marks, both indices and the size register.
  logic [7:0] shadow_ring [RING_SLOTS];
  bit         shadow_written [RING_SLOTS];
  logic [7:0] shadow_rd;
  logic [7:0] shadow_wr;
  logic [3:0] shadow_size_log2;

  // Result items still owed by the block, oldest first.
  res_t pending_results [$];

  int  commands_sent     = 0;
  int  mismatch_count    = 0;
  int  cycle_count       = 0;
  int  sink_hold_cycles  = 0;
  bit  sender_gaps       = 1'b1;
  bit  sink_gaps         = 1'b1;

  // ---------------------------------------------------------------------
  // Ring predictor
  // ---------------------------------------------------------------------

  // Clamp the size register into its legal span and turn it into an index mask.
  function automatic logic [7:0] ring_mask();
    int s;
    s = shadow_size_log2;
    if (s < SIZE_LOG2_MIN) s = SIZE_LOG2_MIN;
    if (s > SIZE_LOG2_MAX) s = SIZE_LOG2_MAX;
    return 8'((1 << s) - 1);
  endfunction

  function automatic logic [7:0] ring_fill();
    logic [7:0] m;
    m = ring_mask();
    return ((shadow_wr & m) - (shadow_rd & m)) & m;
  endfunction

  // Queue one result item; free count reflects the indices as they stand now.
  function automatic void owe_result(logic [7:0] data, status_e st, logic [7:0] cnt, bit last);
    res_t item;
    item.data       = data;
    item.status     = st;
    item.count      = cnt;
    item.free_count = ring_mask() - ring_fill();
    item.last       = last;
    pending_results.push_back(item);
  endfunction

  // Advance the shadow ring by one accepted command and queue what it must produce.
  function automatic void ring_predict(logic [2:0] op, logic [7:0] din, logic [5:0] len_raw);
    logic [7:0] m;
    logic [7:0] r;
    logic [7:0] taken [MAX_LEN];
    int         lim;
    int         n;
    bit         found;
    m         = ring_mask();
    lim       = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    shadow_rd = shadow_rd & m;
    shadow_wr = shadow_wr & m;
    r         = shadow_rd;
    n         = 0;
    found     = 1'b0;
    case (op)
      OP_ENQ: begin
        if (((shadow_wr + 8'd1) & m) != r) begin
          shadow_ring[shadow_wr]    = din;
          shadow_written[shadow_wr] = 1'b1;
          shadow_wr                 = (shadow_wr + 8'd1) & m;
          owe_result(8'd0, ST_OK, 8'd1, 1'b1);
        end else begin
          owe_result(8'd0, ST_OVERRUN, 8'd0, 1'b1);
        end
      end
      OP_DEQ: begin
        if (r != shadow_wr) begin
          shadow_rd = (r + 8'd1) & m;
          owe_result(shadow_ring[r], ST_OK, 8'd1, 1'b1);
        end else begin
          owe_result(8'd0, ST_UNDERRUN, 8'd0, 1'b1);
        end
      end
      OP_BULK: begin
        while (r != shadow_wr && n < lim) begin
          taken[n] = shadow_ring[r];
          r = (r + 8'd1) & m;
          n++;
        end
        shadow_rd = r;
        for (int i = 0; i < n; i++)
          owe_result(taken[i], ST_OK, 8'(n), (i + 1 == n) && (n >= lim));
        // Short read or nothing asked: close with a terminator item.
        if (n < lim || n == 0) owe_result(8'd0, ST_OK, 8'(n), 1'b1);
      end
      OP_STR: begin
        while (r != shadow_wr && n < lim && !found) begin
          if (shadow_ring[r] == 8'd0) begin
            found = 1'b1;
          end else begin
            taken[n] = shadow_ring[r];
            n++;
          end
          r = (r + 8'd1) & m;
        end
        if (found) begin
          shadow_rd = r;
          for (int i = 0; i < n; i++) owe_result(taken[i], ST_OK, 8'(n), 1'b0);
          owe_result(8'd0, ST_OK, 8'(n), 1'b1);
        end else begin
          owe_result(8'd0, ST_NOSTR, 8'd0, 1'b1);
        end
      end
      // Query, and the unused codes that behave as a query.
      default: owe_result(8'd0, ST_OK, ring_fill(), 1'b1);
    endcase
  endfunction

  // Check that a read command only walks slots that hold written bytes.
  function automatic bit walk_is_written(logic [2:0] op, logic [5:0] len_raw);
    logic [7:0] m;
    logic [7:0] r;
    logic [7:0] w;
    int         lim;
    if (op != OP_DEQ && op != OP_BULK && op != OP_STR) return 1'b1;
    m   = ring_mask();
    r   = shadow_rd & m;
    w   = shadow_wr & m;
    lim = (op == OP_DEQ) ? 1 : ((len_raw > MAX_LEN) ? MAX_LEN : len_raw);
    for (int n = 0; n < lim && r != w; n++) begin
      if (!shadow_written[r]) return 1'b0;
      if (op == OP_STR && shadow_ring[r] == 8'd0) return 1'b1;
      r = (r + 8'd1) & m;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(1, 3);
    if (pick < 9) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    return ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  // Mostly small reads; zero, the saturation point and the range above it now and then.
  function automatic logic [5:0] random_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 6'd0;
    if (pick == 1) return 6'd32;
    if (pick == 2) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------

  // Offer one command and hold it until the block takes it. A read that would walk
  // into a never-written slot is turned into a query.
  task automatic push_command(input logic [2:0] op, input logic [7:0] din,
                              input logic [5:0] len);
    int gap;
    if (!walk_is_written(op, len)) op = OP_QUERY;
    gap = (sender_gaps && $urandom_range(0, 2) == 0) ? random_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, len, din};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ring_predict(op, din, len);
    commands_sent++;
  endtask

  // Drop valid, then wait until every owed result has come back and the block is quiet.
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the size register while the block is idle.
  task automatic write_ring_size(input logic [3:0] size_log2);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size_log2;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
    shadow_size_log2  = size_log2;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, plus long holds on request
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int pause;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      pause = 0;
      if (sink_hold_cycles > 0) begin
        pause            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
        pause = random_gap();
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, what);
  endfunction

  // Compare every accepted result item with the oldest owed one.
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data       = m_axis_tdata[7:0];
      got.count      = m_axis_tdata[15:8];
      got.free_count = m_axis_tdata[23:16];
      got.status     = status_e'(m_axis_tuser);
      got.last       = m_axis_tlast;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf({"unexpected item: data %02h status %0d count %0d ",
                                 "free %0d last %0b"},
                                got.data, got.status, got.count, got.free_count, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_mismatch($sformatf({"item differs: data %02h/%02h status %0d/%0d count %0d/%0d ",
                                   "free %0d/%0d last %0b/%0b (expected/actual)"},
                                  want.data, got.data, want.status, got.status,
                                  want.count, got.count, want.free_count, got.free_count,
                                  want.last, got.last));
      end
    end
  end

  // Watchdog: end a hung run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every opcode on the empty ring, zero-length and oversize reads, strings that are
  // empty, cut short or complete, bulk reads that end exactly or run short.
  task automatic test_commands();
    push_command(OP_QUERY, 8'h00, 6'd1);
    push_command(OP_DEQ,   8'hFF, 6'd1);
    push_command(OP_BULK,  8'h00, 6'd5);
    push_command(OP_STR,   8'h00, 6'd32);
    push_command(OP_BULK,  8'h00, 6'd0);
    push_command(OP_STR,   8'h00, 6'd0);
    push_command(OP_ENQ,   8'h00, 6'd1);
    push_command(OP_STR,   8'h00, 6'd32);   // terminator first: empty string
    push_command(OP_ENQ,   8'hFF, 6'd63);
    push_command(OP_ENQ,   8'h41, 6'd1);
    push_command(OP_ENQ,   8'h00, 6'd1);
    push_command(OP_STR,   8'h00, 6'd1);    // scan stops before the terminator
    push_command(OP_STR,   8'h00, 6'd63);   // length saturates, string found
    push_command(OP_ENQ,   8'h01, 6'd1);
    push_command(OP_ENQ,   8'h80, 6'd1);
    push_command(OP_ENQ,   8'h7F, 6'd1);
    push_command(OP_ENQ,   8'h55, 6'd1);
    push_command(OP_ENQ,   8'hAA, 6'd1);
    push_command(OP_BULK,  8'h00, 6'd2);    // exactly the length: no terminator
    push_command(OP_DEQ,   8'h00, 6'd1);
    push_command(OP_BULK,  8'h00, 6'd33);   // runs dry: terminator follows
    push_command(3'd5,     8'hFF, 6'd63);
    push_command(3'd6,     8'h00, 6'd0);
    push_command(3'd7,     8'hFF, 6'd63);
    push_command(OP_QUERY, 8'h00, 6'd1);
  endtask

  // Fill the largest ring to the brim (size value above range), overrun it, then drain it.
  task automatic test_full_ring();
    write_ring_size(4'd15);
    while (ring_fill() != ring_mask()) push_command(OP_ENQ, random_byte(), random_length());
    push_command(OP_ENQ,   8'h5A, 6'd1);
    push_command(OP_QUERY, 8'h00, 6'd1);
    push_command(OP_STR,   8'h00, 6'd32);
    while (ring_fill() != 0) push_command(OP_BULK, random_byte(), 6'd32);
    push_command(OP_DEQ,   8'h00, 6'd1);
  endtask

  // Change the size while bytes are held: grow across a wrapped ring, then shrink.
  task automatic test_resize_with_data();
    write_ring_size(4'd3);
    repeat (6) push_command(OP_ENQ, random_byte(), 6'd4);
    repeat (3) push_command(OP_DEQ, 8'h00, 6'd1);
    repeat (4) push_command(OP_ENQ, random_byte(), 6'd4);
    write_ring_size(4'd6);
    push_command(OP_QUERY, 8'h00, 6'd1);
    push_command(OP_BULK,  8'h00, 6'd5);
    push_command(OP_STR,   8'h00, 6'd32);
    repeat (3) push_command(OP_ENQ, random_byte(), 6'd1);
    write_ring_size(4'd1);
    push_command(OP_QUERY, 8'h00, 6'd1);
    push_command(OP_DEQ,   8'h00, 6'd1);
    push_command(OP_ENQ,   8'h33, 6'd1);
    push_command(OP_ENQ,   8'h44, 6'd1);
    push_command(OP_BULK,  8'h00, 6'd32);
    write_ring_size(4'd0);
    push_command(OP_ENQ,   8'h00, 6'd1);
    push_command(OP_STR,   8'h00, 6'd2);
    push_command(OP_QUERY, 8'h00, 6'd1);
  endtask

  // Hold the result side off for a long stretch while commands keep coming, so the
  // result buffer fills and the command side stalls.
  task automatic test_backpressure();
    write_ring_size(4'd8);
    sender_gaps      = 1'b0;
    sink_gaps        = 1'b0;
    sink_hold_cycles = 200;
    for (int i = 0; i < 40; i++) begin
      case (i % 4)
        0, 1:    push_command(OP_ENQ, random_byte(), 6'd3);
        2:       push_command(OP_BULK, 8'h00, 6'd3);
        default: push_command(OP_QUERY, 8'h00, 6'd1);
      endcase
    end
    wait_until_drained();
  endtask

  // Enqueue a run of bytes, mostly closed by a terminator, then read it back as a
  // string; now and then leave the terminator out or cut the length short.
  task automatic random_string_burst();
    int k;
    int cut;
    k = $urandom_range(0, 8);
    repeat (k) push_command(OP_ENQ, 8'($urandom_range(1, 255)), random_length());
    if ($urandom_range(0, 4) != 0) push_command(OP_ENQ, 8'h00, random_length());
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, k) : k + 1 + $urandom_range(0, 3);
    push_command(OP_STR, random_byte(), 6'(cut));
  endtask

  task automatic random_bulk_burst();
    int k;
    k = $urandom_range(0, 10);
    repeat (k) push_command(OP_ENQ, random_byte(), random_length());
    push_command($urandom_range(0, 3) == 0 ? OP_DEQ : OP_BULK, random_byte(),
                 ($urandom_range(0, 3) == 0) ? random_length() : 6'($urandom_range(1, k + 2)));
  endtask

  // Random traffic over many ring sizes, with idling switched on and off per phase.
  task automatic test_random_traffic();
    logic [3:0] sizes [12] = '{4'd1, 4'd0, 4'd2, 4'd3, 4'd5, 4'd8,
                               4'd9, 4'd4, 4'd15, 4'd6, 4'd7, 4'd8};
    int phase_end;
    foreach (sizes[p]) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps   = ($urandom_range(0, 3) != 0);
      write_ring_size((p == 11) ? 4'($urandom_range(0, 15)) : sizes[p]);
      phase_end = commands_sent + 6;
      while (commands_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: random_string_burst();
          4, 5:       random_bulk_burst();
          default:    push_command(3'($urandom_range(0, 7)), random_byte(), random_length());
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    for (int i = 0; i < RING_SLOTS; i++) begin
      shadow_ring[i]    = 8'd0;
      shadow_written[i] = 1'b0;
    end
    shadow_rd        = 8'd0;
    shadow_wr        = 8'd0;
    shadow_size_log2 = SIZE_LOG2_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_full_ring();
    test_resize_with_data();
    test_backpressure();
    test_random_traffic();

    // Let the last results out, then watch a little longer for strays.
    wait_until_drained();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_obuf.sv
rtl/brf_ctrl.sv
rtl/byte_ring_fifo.sv
verif/tb.sv
